[design/ipv4p_pkg.sv]
`timescale 1ns / 1ps

package ipv4p_pkg;

  localparam logic [7:0] PROTO_TCP = 8'd6;
  localparam logic [7:0] PROTO_UDP = 8'd17;

  localparam logic [16:0] COUNT_MAX = 17'h1FFFF;

  localparam logic [7:0] VERSION_MASK = 8'hF0;
  localparam logic [7:0] VERSION_IPV4 = 8'h40;
  localparam logic [3:0] IHL_MIN = 4'd5;
  localparam logic [6:0] TCP_MIN_BYTES = 7'd20;
  localparam logic [6:0] UDP_HDR_BYTES = 7'd8;

  // Byte positions of the fixed IPv4 header fields.
  localparam logic [16:0] POS_VER_IHL = 17'd0;
  localparam logic [16:0] POS_LEN_HI = 17'd2;
  localparam logic [16:0] POS_LEN_LO = 17'd3;
  localparam logic [16:0] POS_PROTO = 17'd9;
  localparam logic [16:0] POS_SRC_FIRST = 17'd12;
  localparam logic [16:0] POS_SRC_LAST = 17'd15;
  localparam logic [16:0] POS_DST_FIRST = 17'd16;
  localparam logic [16:0] POS_DST_LAST = 17'd19;
  localparam logic [16:0] POS_MIN_HDR_END = 17'd20;

  // Byte offsets within the transport header.
  localparam logic [16:0] TP_SPORT_HI = 17'd0;
  localparam logic [16:0] TP_SPORT_LO = 17'd1;
  localparam logic [16:0] TP_DPORT_HI = 17'd2;
  localparam logic [16:0] TP_DPORT_LO = 17'd3;
  localparam logic [16:0] TP_OFFSET = 17'd12;
  localparam logic [16:0] TP_FLAGS = 17'd13;

  localparam logic [2:0] STATUS_OK = 3'd0;
  localparam logic [2:0] STATUS_NOT_IPV4 = 3'd1;
  localparam logic [2:0] STATUS_BAD_IHL = 3'd2;
  localparam logic [2:0] STATUS_LEN_MISMATCH = 3'd3;
  localparam logic [2:0] STATUS_TCP_SHORT = 3'd4;
  localparam logic [2:0] STATUS_UDP_SHORT = 3'd5;
  localparam logic [2:0] STATUS_TRUNCATED = 3'd6;

  typedef struct packed {
    logic [16:0] byte_counter;
    logic [7:0]  version_ihl;
    logic [15:0] length_field;
    logic [7:0]  proto;
    logic [31:0] src_addr;
    logic [31:0] dst_addr;
    logic [15:0] src_port;
    logic [15:0] dst_port;
    logic [11:0] offset_flags;
  } hdr_state_t;

  typedef struct packed {
    logic [15:0] total_length;
    logic [15:0] payload_bytes;
    logic [7:0]  tcp_flag_bits;
    logic [5:0]  transport_header_bytes;
    logic [5:0]  ip_header_bytes;
    logic [15:0] dest_port;
    logic [15:0] source_port;
    logic [31:0] dest_address;
    logic [31:0] source_address;
    logic [7:0]  protocol;
    logic [2:0]  status;
  } result_t;

endpackage

[design/ipv4p_capture.sv]
`timescale 1ns / 1ps

module ipv4p_capture (
  input  ipv4p_pkg::hdr_state_t st,
  input  logic [7:0]            data_byte,
  output ipv4p_pkg::hdr_state_t st_next
);

  logic [16:0] pos;
  logic [3:0]  ihl;
  logic [16:0] tp_start;
  logic [16:0] tp_pos;
  logic        in_transport;

  assign pos = st.byte_counter;
  // The IHL used here is the one held before this word is taken.
  assign ihl = st.version_ihl[3:0];
  assign tp_start = {11'd0, ihl, 2'b00};
  assign tp_pos = pos - tp_start;
  assign in_transport = (pos >= ipv4p_pkg::POS_MIN_HDR_END) && (ihl >= ipv4p_pkg::IHL_MIN)
                        && (pos >= tp_start);

  always_comb begin
    st_next = st;

    if (pos < ipv4p_pkg::COUNT_MAX) begin
      st_next.byte_counter = pos + 17'd1;
    end

    priority if (pos == ipv4p_pkg::POS_VER_IHL) begin
      st_next.version_ihl = data_byte;
    end else if (pos == ipv4p_pkg::POS_LEN_HI) begin
      st_next.length_field[15:8] = data_byte;
    end else if (pos == ipv4p_pkg::POS_LEN_LO) begin
      st_next.length_field[7:0] = data_byte;
    end else if (pos == ipv4p_pkg::POS_PROTO) begin
      st_next.proto = data_byte;
    end else if (pos >= ipv4p_pkg::POS_SRC_FIRST && pos <= ipv4p_pkg::POS_SRC_LAST) begin
      st_next.src_addr = {st.src_addr[23:0], data_byte};
    end else if (pos >= ipv4p_pkg::POS_DST_FIRST && pos <= ipv4p_pkg::POS_DST_LAST) begin
      st_next.dst_addr = {st.dst_addr[23:0], data_byte};
    end else begin
    end

    if (in_transport) begin
      priority if (tp_pos == ipv4p_pkg::TP_SPORT_HI) begin
        st_next.src_port[15:8] = data_byte;
      end else if (tp_pos == ipv4p_pkg::TP_SPORT_LO) begin
        st_next.src_port[7:0] = data_byte;
      end else if (tp_pos == ipv4p_pkg::TP_DPORT_HI) begin
        st_next.dst_port[15:8] = data_byte;
      end else if (tp_pos == ipv4p_pkg::TP_DPORT_LO) begin
        st_next.dst_port[7:0] = data_byte;
      end else if (tp_pos == ipv4p_pkg::TP_OFFSET) begin
        st_next.offset_flags[11:8] = data_byte[7:4];
      end else if (tp_pos == ipv4p_pkg::TP_FLAGS) begin
        st_next.offset_flags[7:0] = data_byte;
      end else begin
      end
    end
  end

endmodule

[design/ipv4p_eval.sv]
`timescale 1ns / 1ps

module ipv4p_eval (
  input  ipv4p_pkg::hdr_state_t st,
  output ipv4p_pkg::result_t    res
);

  logic        is_tcp;
  logic        is_udp;
  logic [5:0]  iphdr;
  logic [5:0]  thdr;
  logic [6:0]  hdrsum;
  logic [6:0]  tcp_min;
  logic [6:0]  udp_min;
  logic [15:0] len;
  logic [2:0]  status;

  assign is_tcp = st.proto == ipv4p_pkg::PROTO_TCP;
  assign is_udp = st.proto == ipv4p_pkg::PROTO_UDP;
  assign iphdr = {st.version_ihl[3:0], 2'b00};
  assign thdr = is_tcp ? {st.offset_flags[11:8], 2'b00} : 6'd0;
  assign len = st.length_field;

  always_comb begin
    if (is_tcp) begin
      hdrsum = {1'b0, iphdr} + {1'b0, thdr};
    end else if (is_udp) begin
      hdrsum = {1'b0, iphdr} + ipv4p_pkg::UDP_HDR_BYTES;
    end else begin
      hdrsum = {1'b0, iphdr};
    end
  end

  assign tcp_min = {1'b0, iphdr} + ipv4p_pkg::TCP_MIN_BYTES;
  assign udp_min = {1'b0, iphdr} + ipv4p_pkg::UDP_HDR_BYTES;

  always_comb begin
    priority if ((st.version_ihl & ipv4p_pkg::VERSION_MASK) != ipv4p_pkg::VERSION_IPV4) begin
      status = ipv4p_pkg::STATUS_NOT_IPV4;
    end else if (st.version_ihl[3:0] < ipv4p_pkg::IHL_MIN) begin
      status = ipv4p_pkg::STATUS_BAD_IHL;
    end else if ({1'b0, len} != st.byte_counter) begin
      status = ipv4p_pkg::STATUS_LEN_MISMATCH;
    end else if (len < {10'd0, iphdr}) begin
      status = ipv4p_pkg::STATUS_TRUNCATED;
    end else if (is_tcp && (len < {9'd0, tcp_min} || len < {9'd0, hdrsum})) begin
      status = ipv4p_pkg::STATUS_TCP_SHORT;
    end else if (is_udp && len < {9'd0, udp_min}) begin
      status = ipv4p_pkg::STATUS_UDP_SHORT;
    end else begin
      status = ipv4p_pkg::STATUS_OK;
    end
  end

  always_comb begin
    res.status = status;
    res.protocol = st.proto;
    res.source_address = st.src_addr;
    res.dest_address = st.dst_addr;
    res.source_port = (is_tcp || is_udp) ? st.src_port : 16'd0;
    res.dest_port = (is_tcp || is_udp) ? st.dst_port : 16'd0;
    res.ip_header_bytes = iphdr;
    res.transport_header_bytes = thdr;
    res.tcp_flag_bits = is_tcp ? st.offset_flags[7:0] : 8'd0;
    res.payload_bytes = (len > {9'd0, hdrsum}) ? (len - {9'd0, hdrsum}) : 16'd0;
    res.total_length = len;
  end

endmodule

[design/ipv4_transport_header_parser.sv]
`timescale 1ns / 1ps

// Channel | Direction | Payload
// s_*     | in        | tdata[7:0] packet byte, tlast final byte of packet
// m_*     | out       | tdata[159:0] one parse result per packet
//
// A last byte's result is loaded into the output register from the input register,
// where the byte waits while capture and evaluation run. A byte can be accepted
// in every cycle; only a last byte waits, and only while the output register
// still holds a result that is not taken.
// rst is synchronous and clears the byte count, all captured fields and
// both valid flags.

module ipv4_transport_header_parser (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [7:0]   s_tdata,   // [7:0] data_byte
  input  logic         s_tlast,   // last_byte
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [159:0] m_tdata    // status, protocol, source_address,
                                  // dest_address, source_port, dest_port,
                                  // ip_header_bytes, transport_header_bytes,
                                  // tcp_flag_bits, payload_bytes,
                                  // total_length, one zero pad bit
);

  logic                  in_valid;
  logic [7:0]            in_byte;
  logic                  in_last;
  logic                  out_free;
  logic                  advance;
  ipv4p_pkg::hdr_state_t st;
  ipv4p_pkg::hdr_state_t st_next;
  ipv4p_pkg::result_t    res;

  assign out_free = !m_tvalid || m_tready;
  assign advance = in_valid && (!in_last || out_free);
  assign s_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_byte <= s_tdata;
      in_last <= s_tlast;
    end
  end

  ipv4p_capture u_capture (
    .st        (st),
    .data_byte (in_byte),
    .st_next   (st_next)
  );

  ipv4p_eval u_eval (
    .st  (st_next),
    .res (res)
  );

  // The header state starts afresh after every last word.
  always_ff @(posedge clk) begin
    if (rst) begin
      st <= '0;
    end else if (advance) begin
      st <= in_last ? '0 : st_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance && in_last) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && in_last) begin
      m_tdata <= {1'b0, res};
    end
  end

  a_reset_clears: assert property (@(posedge clk)
    rst |=> (st.byte_counter == 17'd0 && !m_tvalid && !in_valid))
    else $error("reset did not clear the parser state");

  a_last_loads_result: assert property (@(posedge clk) disable iff (rst)
    (advance && in_last) |=> (m_tvalid && st.byte_counter == 17'd0))
    else $error("last word did not produce a result and clear the count");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |-> !(advance && in_last))
    else $error("pending result overwritten");

  a_status_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[2:0] <= ipv4p_pkg::STATUS_TRUNCATED))
    else $error("status code out of range");

endmodule

[bench/ipv4_transport_header_parser_test.sv]
`timescale 1ns / 1ps

module ipv4_transport_header_parser_test;
  import ipv4p_pkg::*;

  localparam int STALL_LIMIT = 2000;
  localparam int DRAIN_CYCLES = 20;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } packet_byte_t;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         s_tvalid = 1'b0;
  logic         s_tready;
  logic [7:0]   s_tdata = 8'd0;
  logic         s_tlast = 1'b0;
  logic         m_tvalid;
  logic         m_tready = 1'b0;
  logic [159:0] m_tdata;

  packet_byte_t queued_bytes[$];
  result_t      header_results_due[$];
  hdr_state_t   parse_state = '0;

  logic s_fire = 1'b0;
  logic quiet_tail = 1'b0;
  int   fail_count = 0;
  int   bytes_queued = 0;
  int   s_gap = 0;
  int   m_gap = 0;
  int   s_idle_pct = 10;
  int   m_idle_pct = 10;
  int   drive_cycle = 0;
  int   stalled_cycles = 0;

  ipv4_transport_header_parser dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Captures one packet byte into the header state and, on the last byte, works out
  // the parse result and clears the state for the next packet.
  function automatic void parse_byte(logic [7:0] b, logic last);
    int pos;
    int ihl;
    int tp_start;
    int rel;
    int ip_hdr;
    int tp_hdr;
    int hdr_sum;
    int len;
    int cnt;
    logic is_tcp;
    logic is_udp;
    result_t r;
    pos = parse_state.byte_counter;
    ihl = parse_state.version_ihl[3:0];
    tp_start = ihl * 4;
    if (pos == POS_VER_IHL) begin
      parse_state.version_ihl = b;
    end else if (pos == POS_LEN_HI) begin
      parse_state.length_field[15:8] = b;
    end else if (pos == POS_LEN_LO) begin
      parse_state.length_field[7:0] = b;
    end else if (pos == POS_PROTO) begin
      parse_state.proto = b;
    end else if (pos >= POS_SRC_FIRST && pos <= POS_SRC_LAST) begin
      parse_state.src_addr = {parse_state.src_addr[23:0], b};
    end else if (pos >= POS_DST_FIRST && pos <= POS_DST_LAST) begin
      parse_state.dst_addr = {parse_state.dst_addr[23:0], b};
    end
    // Transport bytes are only captured behind a header of legal length.
    if (pos >= POS_MIN_HDR_END && ihl >= IHL_MIN && pos >= tp_start) begin
      rel = pos - tp_start;
      if (rel == TP_SPORT_HI) parse_state.src_port[15:8] = b;
      else if (rel == TP_SPORT_LO) parse_state.src_port[7:0] = b;
      else if (rel == TP_DPORT_HI) parse_state.dst_port[15:8] = b;
      else if (rel == TP_DPORT_LO) parse_state.dst_port[7:0] = b;
      else if (rel == TP_OFFSET) parse_state.offset_flags[11:8] = b[7:4];
      else if (rel == TP_FLAGS) parse_state.offset_flags[7:0] = b;
    end
    if (parse_state.byte_counter != COUNT_MAX) parse_state.byte_counter++;
    if (last) begin
      ihl = parse_state.version_ihl[3:0];
      ip_hdr = ihl * 4;
      len = parse_state.length_field;
      cnt = parse_state.byte_counter;
      is_tcp = parse_state.proto == PROTO_TCP;
      is_udp = parse_state.proto == PROTO_UDP;
      r = '0;
      r.protocol = parse_state.proto;
      r.source_address = parse_state.src_addr;
      r.dest_address = parse_state.dst_addr;
      r.ip_header_bytes = ip_hdr[5:0];
      r.total_length = parse_state.length_field;
      tp_hdr = 0;
      if (is_tcp) begin
        tp_hdr = int'(parse_state.offset_flags[11:8]) * 4;
        r.transport_header_bytes = tp_hdr[5:0];
        r.tcp_flag_bits = parse_state.offset_flags[7:0];
      end else if (is_udp) begin
        tp_hdr = UDP_HDR_BYTES;
      end
      if (is_tcp || is_udp) begin
        r.source_port = parse_state.src_port;
        r.dest_port = parse_state.dst_port;
      end
      hdr_sum = ip_hdr + tp_hdr;
      if ((parse_state.version_ihl & VERSION_MASK) != VERSION_IPV4) r.status = STATUS_NOT_IPV4;
      else if (ihl < IHL_MIN) r.status = STATUS_BAD_IHL;
      else if (len != cnt) r.status = STATUS_LEN_MISMATCH;
      else if (len < ip_hdr) r.status = STATUS_TRUNCATED;
      else if (is_tcp && (len < ip_hdr + TCP_MIN_BYTES || len < hdr_sum))
        r.status = STATUS_TCP_SHORT;
      else if (is_udp && len < ip_hdr + UDP_HDR_BYTES) r.status = STATUS_UDP_SHORT;
      else r.status = STATUS_OK;
      r.payload_bytes = (len > hdr_sum) ? 16'(len - hdr_sum) : 16'd0;
      header_results_due.push_back(r);
      parse_state = '0;
    end
  endfunction

  task automatic check_field(string name, logic [31:0] got, logic [31:0] want);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fail_count++;
    end
  endtask

  // Queues one packet of n bytes. A fill of -1 gives random content; the header
  // fields that steer the parser are then laid over it.
  task automatic queue_packet(int ver, int ihl, int proto, int n, int len_field, int doff,
                              int flags, int fill);
    logic [15:0] len16;
    logic [7:0]  b;
    int          tp;
    packet_byte_t w;
    len16 = (len_field < 0) ? n[15:0] : len_field[15:0];
    tp = ihl * 4;
    for (int i = 0; i < n; i++) begin
      b = (fill < 0) ? 8'($urandom) : fill[7:0];
      if (i == POS_VER_IHL) b = {ver[3:0], ihl[3:0]};
      else if (i == POS_LEN_HI) b = len16[15:8];
      else if (i == POS_LEN_LO) b = len16[7:0];
      else if (i == POS_PROTO) b = proto[7:0];
      else if (ihl >= IHL_MIN && i == tp + TP_OFFSET) b = {doff[3:0], b[3:0]};
      else if (ihl >= IHL_MIN && i == tp + TP_FLAGS) b = flags[7:0];
      w.data = b;
      w.last = (i == n - 1);
      queued_bytes.push_back(w);
    end
    bytes_queued += n;
  endtask

  // Mostly well-formed packets with random content; the rest malformed in one way, or random in every field.
  task automatic random_packet();
    int kind;
    int ihl;
    int ip_hdr;
    int tp_hdr;
    int doff;
    int proto;
    int n;
    int len;
    int ver;
    kind = $urandom_range(0, 99);
    ihl = ($urandom_range(0, 3) == 0) ? $urandom_range(5, 15) : 5;
    ip_hdr = ihl * 4;
    case ($urandom_range(0, 2))
      0: proto = PROTO_TCP;
      1: proto = PROTO_UDP;
      default: proto = $urandom_range(0, 255);
    endcase
    doff = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 15) : $urandom_range(5, 15);
    tp_hdr = (proto == PROTO_TCP) ? doff * 4 : (proto == PROTO_UDP) ? UDP_HDR_BYTES : 0;
    n = ip_hdr + tp_hdr + $urandom_range(0, 24);
    if (kind < 60) begin
      queue_packet(4, ihl, proto, n, -1, doff, $urandom_range(0, 255), -1);
    end else if (kind < 68) begin
      case ($urandom_range(0, 2))
        0: len = n + $urandom_range(1, 3);
        1: len = n - 1;
        default: len = $urandom_range(0, 65535);
      endcase
      queue_packet(4, ihl, proto, n, len, doff, $urandom_range(0, 255), -1);
    end else if (kind < 74) begin
      ver = $urandom_range(0, 14);
      if (ver >= 4) ver++;
      queue_packet(ver, ihl, proto, n, -1, doff, $urandom_range(0, 255), -1);
    end else if (kind < 79) begin
      queue_packet(4, $urandom_range(0, 4), proto, $urandom_range(1, 60), -1, doff,
                   $urandom_range(0, 255), -1);
    end else if (kind < 85) begin
      queue_packet(4, ihl, proto, $urandom_range(1, ip_hdr - 1), -1, doff,
                   $urandom_range(0, 255), -1);
    end else if (kind < 90) begin
      queue_packet(4, ihl, PROTO_TCP, ip_hdr + $urandom_range(0, 19), -1, doff,
                   $urandom_range(0, 255), -1);
    end else if (kind < 94) begin
      queue_packet(4, ihl, PROTO_UDP, ip_hdr + $urandom_range(0, 7), -1, doff,
                   $urandom_range(0, 255), -1);
    end else begin
      queue_packet($urandom_range(0, 15), $urandom_range(0, 15), $urandom_range(0, 255),
                   $urandom_range(1, 80), $urandom_range(0, 65535), $urandom_range(0, 15),
                   $urandom_range(0, 255), -1);
    end
  endtask

  function automatic int pick_idle_pct();
    case ($urandom_range(0, 2))
      0: return 0;
      1: return 8;
      default: return 30;
    endcase
  endfunction

  // Sender: a word on offer stays until it is taken; gaps only open between words.
  always @(negedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_fire) void'(queued_bytes.pop_front());
      if (drive_cycle % 256 == 0) begin
        s_idle_pct = pick_idle_pct();
        m_idle_pct = pick_idle_pct();
      end
      drive_cycle++;
      if (s_tvalid && !s_fire) begin
        // Holding the current word.
      end else if (s_gap > 0 && !quiet_tail) begin
        s_gap--;
        s_tvalid <= 1'b0;
      end else if (!quiet_tail && $urandom_range(0, 99) < s_idle_pct) begin
        s_gap = $urandom_range(1, 18) - 1;
        s_tvalid <= 1'b0;
      end else if (queued_bytes.size() != 0) begin
        s_tvalid <= 1'b1;
        s_tdata <= queued_bytes[0].data;
        s_tlast <= queued_bytes[0].last;
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else if (quiet_tail) begin
      m_tready <= 1'b1;
    end else if (m_gap > 0) begin
      m_gap--;
      m_tready <= 1'b0;
    end else if ($urandom_range(0, 99) < m_idle_pct) begin
      m_gap = $urandom_range(1, 18) - 1;
      m_tready <= 1'b0;
    end else begin
      m_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    result_t got;
    result_t want;
    s_fire = !rst && s_tvalid && s_tready;
    if (s_fire) parse_byte(s_tdata, s_tlast);
    if (!rst && m_tvalid && m_tready) begin
      got = result_t'(m_tdata[158:0]);
      if (header_results_due.size() == 0) begin
        $error("result word arrived with no packet awaiting one");
        fail_count++;
      end else begin
        want = header_results_due.pop_front();
        check_field("status", got.status, want.status);
        check_field("protocol", got.protocol, want.protocol);
        check_field("source_address", got.source_address, want.source_address);
        check_field("dest_address", got.dest_address, want.dest_address);
        check_field("source_port", got.source_port, want.source_port);
        check_field("dest_port", got.dest_port, want.dest_port);
        check_field("ip_header_bytes", got.ip_header_bytes, want.ip_header_bytes);
        check_field("transport_header_bytes", got.transport_header_bytes,
                    want.transport_header_bytes);
        check_field("tcp_flag_bits", got.tcp_flag_bits, want.tcp_flag_bits);
        check_field("payload_bytes", got.payload_bytes, want.payload_bytes);
        check_field("total_length", got.total_length, want.total_length);
        check_field("pad_bit", m_tdata[159], 1'b0);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || s_fire || (m_tvalid && m_tready)) begin
      stalled_cycles <= 0;
    end else if (stalled_cycles >= STALL_LIMIT) begin
      $display("FAILED: results differ");
      $finish;
    end else begin
      stalled_cycles <= stalled_cycles + 1;
    end
  end

  initial begin
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Extremes of content, every status and the awkward lengths.
    queue_packet(4, 5, PROTO_TCP, 40, -1, 5, 8'hFF, 8'hFF);
    queue_packet(4, 5, PROTO_UDP, 28, -1, 0, 0, 8'h00);
    queue_packet(4, 5, 1, 64, -1, 0, 0, -1);
    queue_packet(4, 15, PROTO_TCP, 150, -1, 15, 8'h12, -1);
    queue_packet(4, 5, PROTO_TCP, 48, -1, 0, 8'hA5, -1);
    queue_packet(4, 6, PROTO_TCP, 49, -1, 5, 8'h18, -1);
    queue_packet(6, 5, PROTO_TCP, 40, -1, 5, 8'h02, -1);
    queue_packet(15, 15, 8'hFF, 70, 70, 15, 8'hFF, 8'hFF);
    queue_packet(4, 0, PROTO_UDP, 40, -1, 5, 0, -1);
    queue_packet(4, 4, PROTO_TCP, 40, -1, 5, 0, -1);
    queue_packet(4, 5, PROTO_TCP, 40, 41, 5, 8'h10, -1);
    queue_packet(4, 5, PROTO_TCP, 12, -1, 5, 0, -1);
    queue_packet(4, 15, PROTO_UDP, 30, -1, 5, 0, -1);
    queue_packet(4, 5, PROTO_TCP, 30, -1, 5, 0, -1);
    queue_packet(4, 5, PROTO_TCP, 40, -1, 15, 8'h01, -1);
    queue_packet(4, 5, PROTO_UDP, 25, -1, 0, 0, -1);
    queue_packet(4, 5, PROTO_TCP, 1, -1, 5, 0, -1);
    queue_packet(4, 5, PROTO_TCP, 3, -1, 5, 0, -1);

    // Hold the sender back until every directed result is in.
    while (queued_bytes.size() != 0 || header_results_due.size() != 0) @(posedge clk);

    while (bytes_queued < 1000) random_packet();
    while (queued_bytes.size() != 0) @(posedge clk);

    quiet_tail = 1'b1;
    repeat (4) random_packet();
    while (queued_bytes.size() != 0 || header_results_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (fail_count == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
